@@ hw/rtl/sitda_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types, character codes and the power-of-ten table for the signed
// integer to decimal text converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned MULT_W     = 34;
    localparam int unsigned MAX_DIGITS = 10;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
        logic [POS_W-1:0]   top_pos;
    } t_item;

    function automatic logic [MULT_W-1:0] pow10(input logic [POS_W-1:0] k);
        logic [MULT_W-1:0] r;
        case (k)
            4'd0:    r = 34'd1;
            4'd1:    r = 34'd10;
            4'd2:    r = 34'd100;
            4'd3:    r = 34'd1000;
            4'd4:    r = 34'd10000;
            4'd5:    r = 34'd100000;
            4'd6:    r = 34'd1000000;
            4'd7:    r = 34'd10000000;
            4'd8:    r = 34'd100000000;
            4'd9:    r = 34'd1000000000;
            default: r = 34'd0;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/sitda_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_front
// Takes the input value, forms sign and magnitude, then counts the decimal
// digits so the back end can start at the leading digit.
// ----------------------------------------------------------------------------
module sitda_front
    import sitda_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_item_valid,
    input  logic               i_item_ready,
    output t_item              o_item
);

    logic               r_valid;
    logic               r_neg;
    logic [VALUE_W-1:0] r_mag;
    logic               n_neg;
    logic [VALUE_W-1:0] n_mag;
    logic [POS_W-1:0]   w_top_pos;

    assign o_ready = !r_valid || i_item_ready;

    assign n_neg = i_value[VALUE_W-1];
    assign n_mag = n_neg ? (~i_value + VALUE_W'(1)) : i_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_neg <= n_neg;
            r_mag <= n_mag;
        end
    end

    // digit count minus one: number of powers of ten from 10 to 10^9 not above the magnitude
    always_comb begin
        w_top_pos = '0;
        for (int k = 1; k < MAX_DIGITS; k++) begin
            if ({{(MULT_W-VALUE_W){1'b0}}, r_mag} >= pow10(POS_W'(k))) begin
                w_top_pos = w_top_pos + POS_W'(1);
            end
        end
    end

    assign o_item_valid   = r_valid;
    assign o_item.neg     = r_neg;
    assign o_item.mag     = r_mag;
    assign o_item.top_pos = w_top_pos;

endmodule

@@ hw/rtl/sitda_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_queue
// Two-entry queue of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module sitda_queue
    import sitda_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr_valid,
    output logic  o_wr_ready,
    input  t_item i_wr_item,
    output logic  o_rd_valid,
    input  logic  i_rd_ready,
    output t_item o_rd_item
);

    t_item       r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        w_push;
    logic        w_pop;

    assign o_wr_ready = (r_count != 2'd2);
    assign o_rd_valid = (r_count != 2'd0);
    assign o_rd_item  = r_mem[r_rd_ptr];
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

endmodule

@@ hw/rtl/sitda_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_back
// Emits the minus sign if negative, then one decimal digit per cycle unless the
// output stalls, leading digit first, comparing the remainder to d * 10^pos.
// ----------------------------------------------------------------------------
module sitda_back
    import sitda_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_item_valid,
    output logic       o_item_ready,
    input  t_item      i_item,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_text_byte,
    output logic       o_is_last
);

    logic               r_busy;
    logic               r_sign_pend;
    logic [VALUE_W-1:0] r_mag;
    logic [POS_W-1:0]   r_pos;
    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_last;

    logic               w_step;
    logic               w_done;
    logic [3:0]         w_digit;
    logic [MULT_W-1:0]  w_sub;
    logic [MULT_W-1:0]  w_mult;

    // digit = largest d with d * 10^pos not above the remainder
    always_comb begin
        w_digit = '0;
        w_sub   = '0;
        for (int d = 1; d < 10; d++) begin
            w_mult = pow10(r_pos) * MULT_W'(d);
            if ({{(MULT_W-VALUE_W){1'b0}}, r_mag} >= w_mult) begin
                w_digit = 4'(d);
                w_sub   = w_mult;
            end
        end
    end

    assign w_step       = r_busy && (!r_out_valid || i_ready);
    assign w_done       = w_step && !r_sign_pend && (r_pos == '0);
    assign o_item_ready = !r_busy || w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_item_ready) begin
                r_busy <= i_item_valid;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_item_ready && i_item_valid) begin
            r_sign_pend <= i_item.neg;
            r_mag       <= i_item.mag;
            r_pos       <= i_item.top_pos;
        end else if (w_step) begin
            if (r_sign_pend) begin
                r_sign_pend <= 1'b0;
            end else begin
                r_mag <= r_mag - w_sub[VALUE_W-1:0];
                r_pos <= r_pos - POS_W'(1);
            end
        end
        if (w_step) begin
            if (r_sign_pend) begin
                r_out_byte <= CHAR_MINUS;
                r_out_last <= 1'b0;
            end else begin
                r_out_byte <= CHAR_ZERO + {4'd0, w_digit};
                r_out_last <= (r_pos == '0);
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_text_byte = r_out_byte;
    assign o_is_last   = r_out_last;

endmodule

@@ hw/rtl/signed_int_to_decimal_ascii.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer to its decimal ASCII text, one byte per
// output transaction, leading digit first, last byte flagged.
//
//   channel  direction  handshake            payload
//   input    in         i_valid / o_ready    i_value[31:0]
//   output   out        o_valid / i_ready    o_text_byte[7:0], o_is_last
//
// Each number produces 1 to 11 characters; the back end emits one character
// per cycle while the output is not stalled. The first byte passes through the
// front register, the queue and the back end's state and output registers.
// Reset clears all control state; the back end overlaps loading the next
// number with its final digit. Front and back stall independently through a
// two-entry queue.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii
    import sitda_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_text_byte,
    output logic               o_is_last
);

    logic  w_f_valid;
    logic  w_f_ready;
    t_item w_f_item;
    logic  w_b_valid;
    logic  w_b_ready;
    t_item w_b_item;

    sitda_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value      (i_value),
        .o_item_valid (w_f_valid),
        .i_item_ready (w_f_ready),
        .o_item       (w_f_item)
    );

    sitda_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_f_valid),
        .o_wr_ready (w_f_ready),
        .i_wr_item  (w_f_item),
        .o_rd_valid (w_b_valid),
        .i_rd_ready (w_b_ready),
        .o_rd_item  (w_b_item)
    );

    sitda_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_b_valid),
        .o_item_ready (w_b_ready),
        .i_item       (w_b_item),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_text_byte  (o_text_byte),
        .o_is_last    (o_is_last)
    );

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_text_byte == CHAR_MINUS)) |-> !o_is_last)
        else $error("minus sign flagged as last byte");

    a_byte_is_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_text_byte == CHAR_MINUS) ||
                     ((o_text_byte >= CHAR_ZERO) && (o_text_byte <= CHAR_NINE))))
        else $error("output byte is neither digit nor minus");

    a_no_zero_after_minus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(o_valid && i_ready && (o_text_byte == CHAR_MINUS)) && o_valid)
            |-> (o_text_byte != CHAR_ZERO))
        else $error("leading zero after minus sign");

endmodule
